@@ sv/lcmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmc_pkg
// Types, constants and tables shared by the material classifier files.
// ----------------------------------------------------------------------------
package lcmc_pkg;

    localparam int ENTRY_COUNT  = 11;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 11;
    localparam int ATAN_LEN     = 24;

    // entries actually tried, CORDIC iterations actually run
    localparam int TRIED = (ENTRY_COUNT < TABLE_LEN) ? ENTRY_COUNT : TABLE_LEN;
    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

    localparam int XW   = 24;   // CORDIC x, y
    localparam int ZW   = 23;   // angle, 1/4096 degree
    localparam int CHW  = 12;   // chroma, sixteenths
    localparam int HUW  = 13;   // hue, sixteenths of a degree
    localparam int SCW  = 17;   // score, 1/64
    localparam int PW   = 40;   // magnitude product
    localparam int STW  = 5;    // CORDIC step index
    localparam int ENW  = 4;    // entry index

    localparam logic [15:0]         INV_GAIN  = 16'd39797;
    localparam logic signed [ZW-1:0] DEG180   = 23'sd737280;
    localparam logic signed [ZW-1:0] DEG360   = 23'sd1474560;
    localparam logic [HUW-1:0]      HUE_FULL  = 13'd5760;
    localparam logic [CHW-1:0]      ACHROMATIC_LIMIT = 12'd800;
    localparam int                  FULL_RANGE_SPAN  = 5744;
    localparam logic [ENW-1:0]      METAL_FALLBACK      = 4'd2;
    localparam logic [ENW-1:0]      DIELECTRIC_FALLBACK = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_METAL_THRESHOLD  = 2'd0;
    localparam logic [1:0] CFG_LIGHTNESS_MARGIN = 2'd1;
    localparam logic [1:0] CFG_HUE_PENALTY      = 2'd2;

    typedef struct packed {
        logic [10:0]        lightness;
        logic signed [11:0] green_red;
        logic signed [11:0] blue_yellow;
        logic [7:0]         metallic;
    } t_pixel;

    typedef struct packed {
        logic [3:0] material_index;
        logic       used_fallback;
    } t_result;

    typedef struct packed {
        logic [10:0]    lo;
        logic [10:0]    hi;
        logic [CHW-1:0] chroma_max;
        logic [HUW-1:0] hue_lo;
        logic [HUW-1:0] hue_hi;
        logic           metal;
    } t_surface;

    // one CORDIC cell's data
    typedef struct packed {
        logic                  valid;
        logic signed [XW-1:0]  x;
        logic signed [XW-1:0]  y;
        logic signed [ZW-1:0]  z;
        logic                  zero;
        logic [10:0]           lightness;
        logic                  metal;
    } t_cordic;

    // one match cell's data
    typedef struct packed {
        logic           valid;
        logic [10:0]    lightness;
        logic [CHW-1:0] chroma;
        logic [HUW-1:0] hue;
        logic           metal;
        logic           found;
        logic [SCW-1:0] best;
        logic [ENW-1:0] idx;
    } t_match;

    function automatic logic signed [ZW-1:0] atan_deg(input logic [STW-1:0] i);
        case (i)
            5'd0:    atan_deg = 23'sd184320;
            5'd1:    atan_deg = 23'sd108810;
            5'd2:    atan_deg = 23'sd57492;
            5'd3:    atan_deg = 23'sd29184;
            5'd4:    atan_deg = 23'sd14649;
            5'd5:    atan_deg = 23'sd7331;
            5'd6:    atan_deg = 23'sd3667;
            5'd7:    atan_deg = 23'sd1833;
            5'd8:    atan_deg = 23'sd917;
            5'd9:    atan_deg = 23'sd458;
            5'd10:   atan_deg = 23'sd229;
            5'd11:   atan_deg = 23'sd115;
            5'd12:   atan_deg = 23'sd57;
            5'd13:   atan_deg = 23'sd29;
            5'd14:   atan_deg = 23'sd14;
            5'd15:   atan_deg = 23'sd7;
            5'd16:   atan_deg = 23'sd4;
            5'd17:   atan_deg = 23'sd2;
            5'd18:   atan_deg = 23'sd1;
            default: atan_deg = 23'sd0;
        endcase
    endfunction

    function automatic t_surface surface(input logic [ENW-1:0] k);
        case (k)
            4'd0:    surface = '{11'd1120, 11'd1600, 12'd3200, 13'd0,    13'd5760, 1'b1};
            4'd1:    surface = '{11'd480,  11'd1120, 12'd3200, 13'd0,    13'd5760, 1'b1};
            4'd2:    surface = '{11'd0,    11'd480,  12'd3200, 13'd0,    13'd5760, 1'b1};
            4'd3:    surface = '{11'd240,  11'd1280, 12'd3200, 13'd1440, 13'd2560, 1'b0};
            4'd4:    surface = '{11'd160,  11'd960,  12'd3200, 13'd3200, 13'd4480, 1'b0};
            4'd5:    surface = '{11'd0,    11'd400,  12'd240,  13'd0,    13'd5760, 1'b0};
            4'd6:    surface = '{11'd320,  11'd880,  12'd3200, 13'd480,  13'd1280, 1'b0};
            4'd7:    surface = '{11'd560,  11'd1200, 12'd192,  13'd0,    13'd5760, 1'b0};
            4'd8:    surface = '{11'd960,  11'd1600, 12'd240,  13'd0,    13'd5760, 1'b0};
            4'd9:    surface = '{11'd640,  11'd1520, 12'd160,  13'd0,    13'd5760, 1'b0};
            default: surface = '{11'd0,    11'd1600, 12'd3200, 13'd0,    13'd5760, 1'b0};
        endcase
    endfunction

endpackage

@@ sv/lcmc_cordic_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmc_cordic_cell
// One registered CORDIC vectoring iteration; step index selects shift/angle.
// ----------------------------------------------------------------------------
module lcmc_cordic_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic [lcmc_pkg::STW-1:0]       i_step,
    input  lcmc_pkg::t_cordic              i_d,
    output lcmc_pkg::t_cordic              o_d
);

    logic signed [lcmc_pkg::XW-1:0] dx;
    logic signed [lcmc_pkg::XW-1:0] dy;
    logic signed [lcmc_pkg::ZW-1:0] ang;
    lcmc_pkg::t_cordic              n_d;
    lcmc_pkg::t_cordic              r_d;
    logic                           r_valid;

    always_comb begin
        dx  = i_d.y >>> i_step;
        dy  = i_d.x >>> i_step;
        ang = lcmc_pkg::atan_deg(i_step);
        n_d = i_d;
        if (i_d.y > 0) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + ang;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_d.valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    always_comb begin
        o_d       = r_d;
        o_d.valid = r_valid;
    end

endmodule

@@ sv/lcmc_match_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmc_match_cell
// Filters and scores one table entry, keeps the running best, registers it.
// ----------------------------------------------------------------------------
module lcmc_match_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [lcmc_pkg::ENW-1:0]  i_entry,
    input  logic [5:0]                i_margin,
    input  logic [11:0]               i_hue_pen,
    input  lcmc_pkg::t_match          i_d,
    output lcmc_pkg::t_match          o_d
);

    lcmc_pkg::t_surface        e;
    logic signed [13:0]        lt;
    logic signed [13:0]        lo_m;
    logic signed [13:0]        hi_m;
    logic signed [13:0]        ldiff;
    logic [12:0]               dabs;
    logic [lcmc_pkg::SCW-1:0]  exc;
    logic [lcmc_pkg::SCW-1:0]  pen;
    logic [lcmc_pkg::SCW-1:0]  score;
    logic                      pass;
    logic                      in_range;
    lcmc_pkg::t_match          n_d;
    lcmc_pkg::t_match          r_d;
    logic                      r_valid;

    always_comb begin
        e    = lcmc_pkg::surface(i_entry);
        lt   = $signed({3'b000, i_d.lightness});
        lo_m = $signed({3'b000, e.lo}) - $signed({8'b0, i_margin});
        hi_m = $signed({3'b000, e.hi}) + $signed({8'b0, i_margin});
        pass = (e.metal == i_d.metal) && !(lt < lo_m) && !(lt > hi_m);

        ldiff = $signed({2'b00, i_d.lightness, 1'b0})
              - ($signed({3'b000, e.lo}) + $signed({3'b000, e.hi}));
        dabs  = ldiff[13] ? 13'(-ldiff) : ldiff[12:0];

        exc = '0;
        if (e.chroma_max < lcmc_pkg::ACHROMATIC_LIMIT && i_d.chroma > e.chroma_max) begin
            exc = {2'b00, (i_d.chroma - e.chroma_max), 3'b000};
        end

        in_range = (e.hue_lo <= e.hue_hi)
                 ? (i_d.hue >= e.hue_lo && i_d.hue <= e.hue_hi)
                 : (i_d.hue >= e.hue_lo || i_d.hue <= e.hue_hi);
        pen = '0;
        if ((int'(e.hue_hi) - int'(e.hue_lo) < lcmc_pkg::FULL_RANGE_SPAN) && !in_range) begin
            pen = {3'b000, i_hue_pen, 2'b00};
        end

        score = {4'b0000, dabs} + exc + pen;

        n_d = i_d;
        if (pass && (!i_d.found || score < i_d.best)) begin
            n_d.found = 1'b1;
            n_d.best  = score;
            n_d.idx   = i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_d.valid;
        end
        if (i_en) begin
            r_d <= n_d;
        end
    end

    always_comb begin
        o_d       = r_d;
        o_d.valid = r_valid;
    end

endmodule

@@ sv/lab_color_material_classifier_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lab_color_material_classifier_unit
// CIELAB + metallic pixel classifier: CORDIC cell chain for chroma and hue,
// then a chain of match cells, one per table entry, carrying the best score.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | i_in_valid/o_in_ready | i_in_data   (t_pixel)
//  out     | output    | o_out_valid/i_out_ready| o_out_data (t_result)
//  cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One pixel per clock while the output is not stalled. The pipe, in order:
// input register, one cell per CORDIC step, the magnitude multiply, one
// cell per entry; the last match cell is the output register.
// Reset (synchronous, active low) empties the pipe and loads register
// defaults. A stall at the output freezes the whole chain; o_in_ready drops
// only while a result waits and is not taken. Config writes always transfer.
// ----------------------------------------------------------------------------
module lab_color_material_classifier_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lcmc_pkg::t_pixel  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output lcmc_pkg::t_result o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [11:0]       i_cfg_data
);

    // configuration registers
    logic [7:0]  r_metal_thr;
    logic [5:0]  r_margin;
    logic [11:0] r_hue_pen;

    // chain advances together
    logic en;

    lcmc_pkg::t_cordic c [0:lcmc_pkg::NSTEP];
    lcmc_pkg::t_match  m [0:lcmc_pkg::TRIED];

    lcmc_pkg::t_cordic n_head;
    lcmc_pkg::t_cordic r_head;
    logic              r_head_valid;

    logic signed [lcmc_pkg::XW-1:0] ax;
    logic signed [lcmc_pkg::XW-1:0] by;

    // finish stage
    logic signed [lcmc_pkg::ZW-1:0] zf;
    logic [lcmc_pkg::XW-1:0]        xc;
    logic [lcmc_pkg::ZW-1:0]        zr;
    logic [lcmc_pkg::HUW-1:0]       hraw;
    logic [lcmc_pkg::PW-1:0]        n_prod;
    logic [lcmc_pkg::HUW-1:0]       n_hue;
    logic [lcmc_pkg::PW-1:0]        r_prod;
    logic [lcmc_pkg::HUW-1:0]       r_hue;
    logic                           r_zero;
    logic [10:0]                    r_light;
    logic                           r_metal;
    logic                           r_fin_valid;

    assign en          = !m[lcmc_pkg::TRIED].valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metal_thr <= 8'd128;
            r_margin    <= 6'd8;
            r_hue_pen   <= 12'd800;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lcmc_pkg::CFG_METAL_THRESHOLD:  r_metal_thr <= i_cfg_data[7:0];
                lcmc_pkg::CFG_LIGHTNESS_MARGIN: r_margin    <= i_cfg_data[5:0];
                lcmc_pkg::CFG_HUE_PENALTY:      r_hue_pen   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pre-rotation: left half plane turned by 180 degrees
    always_comb begin
        ax = {{(lcmc_pkg::XW-20){i_in_data.green_red[11]}}, i_in_data.green_red, 8'h00};
        by = {{(lcmc_pkg::XW-20){i_in_data.blue_yellow[11]}}, i_in_data.blue_yellow, 8'h00};
        n_head.valid     = i_in_valid;
        n_head.zero      = (i_in_data.green_red == 12'sd0) && (i_in_data.blue_yellow == 12'sd0);
        n_head.lightness = i_in_data.lightness;
        n_head.metal     = i_in_data.metallic > r_metal_thr;
        if (ax < 0) begin
            n_head.x = -ax;
            n_head.y = -by;
            n_head.z = lcmc_pkg::DEG180;
        end else begin
            n_head.x = ax;
            n_head.y = by;
            n_head.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
        end else if (en) begin
            r_head_valid <= i_in_valid;
        end
        if (en) begin
            r_head <= n_head;
        end
    end

    always_comb begin
        c[0]       = r_head;
        c[0].valid = r_head_valid;
    end

    for (genvar k = 0; k < lcmc_pkg::NSTEP; k++) begin : g_cordic
        lcmc_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (lcmc_pkg::STW'(k)),
            .i_d     (c[k]),
            .o_d     (c[k+1])
        );
    end

    // magnitude scaling and hue rounding
    always_comb begin
        zf     = (c[lcmc_pkg::NSTEP].z < 0) ? c[lcmc_pkg::NSTEP].z + lcmc_pkg::DEG360
                                            : c[lcmc_pkg::NSTEP].z;
        xc     = (c[lcmc_pkg::NSTEP].x < 0) ? '0 : c[lcmc_pkg::NSTEP].x;
        n_prod = lcmc_pkg::PW'(xc) * lcmc_pkg::PW'(lcmc_pkg::INV_GAIN)
               + (lcmc_pkg::PW'(1) << 23);
        zr     = lcmc_pkg::ZW'(zf + 23'sd128);
        hraw   = zr[8 +: lcmc_pkg::HUW];
        n_hue  = (hraw >= lcmc_pkg::HUE_FULL) ? hraw - lcmc_pkg::HUE_FULL : hraw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (en) begin
            r_fin_valid <= c[lcmc_pkg::NSTEP].valid;
        end
        if (en) begin
            r_prod  <= n_prod;
            r_hue   <= n_hue;
            r_zero  <= c[lcmc_pkg::NSTEP].zero;
            r_light <= c[lcmc_pkg::NSTEP].lightness;
            r_metal <= c[lcmc_pkg::NSTEP].metal;
        end
    end

    // zero color gives chroma 0, hue 0; fallback index preset
    always_comb begin
        m[0].valid     = r_fin_valid;
        m[0].lightness = r_light;
        m[0].chroma    = r_zero ? '0 : r_prod[24 +: lcmc_pkg::CHW];
        m[0].hue       = r_zero ? '0 : r_hue;
        m[0].metal     = r_metal;
        m[0].found     = 1'b0;
        m[0].best      = '0;
        m[0].idx       = r_metal ? lcmc_pkg::METAL_FALLBACK : lcmc_pkg::DIELECTRIC_FALLBACK;
    end

    for (genvar k = 0; k < lcmc_pkg::TRIED; k++) begin : g_match
        lcmc_match_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_entry   (lcmc_pkg::ENW'(k)),
            .i_margin  (r_margin),
            .i_hue_pen (r_hue_pen),
            .i_d       (m[k]),
            .o_d       (m[k+1])
        );
    end

    assign o_out_valid               = m[lcmc_pkg::TRIED].valid;
    assign o_out_data.material_index = m[lcmc_pkg::TRIED].idx;
    assign o_out_data.used_fallback  = !m[lcmc_pkg::TRIED].found;

    // fallback result carries one of the two fallback indexes
    a_fallback_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.used_fallback) |->
        (o_out_data.material_index == lcmc_pkg::METAL_FALLBACK ||
         o_out_data.material_index == lcmc_pkg::DIELECTRIC_FALLBACK))
        else $error("fallback result with wrong index");

    // a matched entry lies within the tried part of the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.material_index < lcmc_pkg::ENW'(lcmc_pkg::TRIED) ||
                         o_out_data.used_fallback))
        else $error("matched index beyond table");

    // stalled result is held until transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result changed while stalled");

    // pipe is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule
